[design/swsfd_pkg.sv]
// ----------------------------------------------------------------------------
// swsfd_pkg
// Shared types and constants for the single-wire sensor frame decoder:
// request and result payloads, request and error codes, frame geometry.
// ----------------------------------------------------------------------------
package swsfd_pkg;

    // frame geometry
    localparam int MAX_EDGES      = 48;
    localparam int FRAME_BITS     = 40;
    localparam int FRAME_W        = 40;
    localparam int COUNT_W        = 6;
    localparam int TS_W           = 16;
    localparam int BYTE_W         = 8;
    localparam int FIRST_BIT_EDGE = 3;
    localparam int LAST_BIT_EDGE  = FRAME_BITS + 2;

    // byte positions inside the frame
    localparam int HUM_WHOLE_LSB  = 32;
    localparam int HUM_FRAC_LSB   = 24;
    localparam int TEMP_WHOLE_LSB = 16;
    localparam int TEMP_FRAC_LSB  = 8;
    localparam int CHECKSUM_LSB   = 0;

    // threshold after reset
    localparam logic [TS_W-1:0] THRESHOLD_RESET = TS_W'(110);

    // request codes
    localparam logic [1:0] REQ_START  = 2'd0;
    localparam logic [1:0] REQ_EDGE   = 2'd1;
    localparam logic [1:0] REQ_READ   = 2'd2;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    // frame error codes
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_SHORT    = 2'd1;
    localparam logic [1:0] ERR_CHECKSUM = 2'd2;

    // request payload
    typedef struct packed {
        logic [1:0]      req_type;
        logic [TS_W-1:0] timestamp;
    } req_item_t;

    // result payload
    typedef struct packed {
        logic [BYTE_W-1:0] humidity_whole;
        logic [BYTE_W-1:0] humidity_fraction;
        logic [BYTE_W-1:0] temperature_whole;
        logic [BYTE_W-1:0] temperature_fraction;
        logic [BYTE_W-1:0] received_checksum;
        logic [1:0]        frame_error;
    } rsp_item_t;

    // edge tracker state seen by the result stage
    typedef struct packed {
        logic [COUNT_W-1:0] edge_count;
        logic [FRAME_W-1:0] frame_bits;
    } frame_state_t;

    // request leaving the decode register
    typedef struct packed {
        logic      fire;
        req_item_t item;
    } decode_ctl_t;

endpackage

[design/swsfd_edge_track.sv]
// ----------------------------------------------------------------------------
// swsfd_edge_track
// Holds the bit threshold, previous capture, edge count and frame shift
// register; start and edge requests update the count, capture and frame, and cfg writes set the threshold.
// ----------------------------------------------------------------------------
module swsfd_edge_track
    import swsfd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  decode_ctl_t       ctl,
    input  logic              cfg_write,
    input  logic [TS_W-1:0]   cfg_data,
    output frame_state_t      state
);

    logic [TS_W-1:0]    threshold_reg;
    logic [TS_W-1:0]    prev_capture_reg;
    logic [TS_W-1:0]    prev_capture_next;
    logic [COUNT_W-1:0] edge_count_reg;
    logic [COUNT_W-1:0] edge_count_next;
    logic [FRAME_W-1:0] frame_reg;
    logic [FRAME_W-1:0] frame_next;
    logic [COUNT_W-1:0] count_inc;
    logic [TS_W-1:0]    diff;
    logic               bit_value;
    logic               in_bit_window;

    // edge step: difference, threshold compare, bit window
    assign count_inc     = edge_count_reg + COUNT_W'(1);
    assign diff          = ctl.item.timestamp - prev_capture_reg;
    assign bit_value     = (diff >= threshold_reg);
    assign in_bit_window = (count_inc >= COUNT_W'(FIRST_BIT_EDGE))
                        && (count_inc <= COUNT_W'(LAST_BIT_EDGE));

    // next state per request type
    always_comb
    begin
        prev_capture_next = prev_capture_reg;
        edge_count_next   = edge_count_reg;
        frame_next        = frame_reg;
        if (ctl.fire)
        begin
            unique case (ctl.item.req_type)
                REQ_START:
                begin
                    edge_count_next = '0;
                    frame_next      = '0;
                end
                REQ_EDGE:
                begin
                    if (edge_count_reg < COUNT_W'(MAX_EDGES))
                    begin
                        edge_count_next   = count_inc;
                        prev_capture_next = ctl.item.timestamp;
                        if (in_bit_window)
                        begin
                            frame_next = {frame_reg[FRAME_W-2:0], bit_value};
                        end
                    end
                end
                default:
                begin
                    // reads and unused codes leave the state alone
                end
            endcase
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg    <= THRESHOLD_RESET;
            prev_capture_reg <= '0;
            edge_count_reg   <= '0;
            frame_reg        <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                threshold_reg <= cfg_data;
            end
            prev_capture_reg <= prev_capture_next;
            edge_count_reg   <= edge_count_next;
            frame_reg        <= frame_next;
        end
    end

    assign state.edge_count = edge_count_reg;
    assign state.frame_bits = frame_reg;

endmodule

[design/swsfd_result_stage.sv]
// ----------------------------------------------------------------------------
// swsfd_result_stage
// Splits the frame into bytes, checks length and checksum, and holds the
// result in the output register until the consumer takes it.
// ----------------------------------------------------------------------------
module swsfd_result_stage
    import swsfd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         load,
    input  frame_state_t state,
    input  logic         rsp_stall,
    output logic         rsp_valid,
    output rsp_item_t    rsp_data
);

    rsp_item_t         result;
    logic [BYTE_W-1:0] byte_sum;
    logic              rsp_valid_reg;
    logic              rsp_valid_next;
    rsp_item_t         rsp_data_reg;

    // byte split and checksum
    always_comb
    begin
        result.humidity_whole       = state.frame_bits[HUM_WHOLE_LSB  +: BYTE_W];
        result.humidity_fraction    = state.frame_bits[HUM_FRAC_LSB   +: BYTE_W];
        result.temperature_whole    = state.frame_bits[TEMP_WHOLE_LSB +: BYTE_W];
        result.temperature_fraction = state.frame_bits[TEMP_FRAC_LSB  +: BYTE_W];
        result.received_checksum    = state.frame_bits[CHECKSUM_LSB   +: BYTE_W];
        byte_sum = result.humidity_whole + result.humidity_fraction
                 + result.temperature_whole + result.temperature_fraction;
        if (state.edge_count < COUNT_W'(LAST_BIT_EDGE))
        begin
            result             = '0;
            result.frame_error = ERR_SHORT;
        end
        else if (byte_sum != result.received_checksum)
        begin
            result.frame_error = ERR_CHECKSUM;
        end
        else
        begin
            result.frame_error = ERR_NONE;
        end
    end

    // output valid: set on load, held while stalled
    always_comb
    begin
        if (load)
        begin
            rsp_valid_next = 1'b1;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg && rsp_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rsp_data_reg <= result;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

endmodule

[design/single_wire_sensor_frame_decoder.sv]
// ----------------------------------------------------------------------------
// single_wire_sensor_frame_decoder
// Rebuilds a 40-bit sensor frame from falling-edge timer captures and
// returns its bytes with a length and checksum status on read requests.
// ----------------------------------------------------------------------------
//  channel  handshake          payload      direction
//  req      req_valid/stall    req_item_t   in   start, edge, read requests
//  rsp      rsp_valid/stall    rsp_item_t   out  one result per read
//  cfg      cfg_valid/ready    16-bit data  in   bit threshold
//
// one request per cycle unless req_stall is high; a request waits in the decode
// register, and a read result goes from there into the output register that drives rsp.
// reset clears the valid bits, edge count, capture, frame; threshold is 110.
// a stalled result holds the decode register only when it holds a read;
// start and edge requests keep moving past a stalled result.
// cfg_ready is always high.
// ----------------------------------------------------------------------------
module single_wire_sensor_frame_decoder
    import swsfd_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  req_item_t       req_data,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output rsp_item_t       rsp_data,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [TS_W-1:0] cfg_data
);

    logic         dec_valid_reg;
    logic         dec_valid_next;
    req_item_t    dec_item_reg;
    logic         req_accept;
    logic         out_free;
    logic         dec_is_read;
    decode_ctl_t  ctl;
    frame_state_t state;

    // decode register advance
    assign out_free    = !rsp_valid || !rsp_stall;
    assign dec_is_read = (dec_item_reg.req_type == REQ_READ);
    assign ctl.fire    = dec_valid_reg && (!dec_is_read || out_free);
    assign ctl.item    = dec_item_reg;
    assign req_stall   = dec_valid_reg && !ctl.fire;
    assign req_accept  = req_valid && !req_stall;
    assign cfg_ready   = 1'b1;

    always_comb
    begin
        if (req_accept)
        begin
            dec_valid_next = 1'b1;
        end
        else
        begin
            dec_valid_next = dec_valid_reg && !ctl.fire;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dec_valid_reg <= 1'b0;
        end
        else
        begin
            dec_valid_reg <= dec_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            dec_item_reg <= req_data;
        end
    end

    // edge state
    swsfd_edge_track u_edge_track (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .state     (state)
    );

    // result formation and output register
    swsfd_result_stage u_result_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (ctl.fire && dec_is_read),
        .state     (state),
        .rsp_stall (rsp_stall),
        .rsp_valid (rsp_valid),
        .rsp_data  (rsp_data)
    );

endmodule

[design/swsfd_checker.sv]
// ----------------------------------------------------------------------------
// swsfd_checker
// Port-level checks for the frame decoder: result hold, error codes against
// the bytes shown, and request flow while the result side is empty.
// ----------------------------------------------------------------------------
module swsfd_checker
    import swsfd_pkg::*;
(
    input logic            clk,
    input logic            rst_n,
    input logic            req_stall,
    input logic            rsp_valid,
    input logic            rsp_stall,
    input rsp_item_t       rsp_data
);

    logic [BYTE_W-1:0] sum;

    assign sum = rsp_data.humidity_whole + rsp_data.humidity_fraction
               + rsp_data.temperature_whole + rsp_data.temperature_fraction;

    // stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
        else $error("stalled result changed");

    // short frame gives all-zero bytes
    a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_data.frame_error == ERR_SHORT) |->
            (rsp_data.humidity_whole == '0) && (rsp_data.humidity_fraction == '0)
            && (rsp_data.temperature_whole == '0)
            && (rsp_data.temperature_fraction == '0)
            && (rsp_data.received_checksum == '0))
        else $error("short frame result has nonzero bytes");

    // good status only with matching checksum
    a_good_sum: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_data.frame_error == ERR_NONE) |->
            (sum == rsp_data.received_checksum))
        else $error("good status with checksum mismatch");

    // checksum status only with mismatching checksum
    a_bad_sum: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_data.frame_error == ERR_CHECKSUM) |->
            (sum != rsp_data.received_checksum))
        else $error("checksum error with matching checksum");

    // empty result side never holds back requests
    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid |-> !req_stall)
        else $error("request stalled with no pending result");

endmodule

bind single_wire_sensor_frame_decoder swsfd_checker u_swsfd_checker (.*);

[tb/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the single-wire sensor frame decoder. Requests are
// pushed through a shared sender that keeps a running copy of the decoder
// state and queues the result each read should give. A checker compares every
// result, field by field, against that queue while both sides idle at random.
// ----------------------------------------------------------------------------
module tb_top;
    import swsfd_pkg::*;

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            req_valid = 1'b0;
    logic            req_stall;
    req_item_t       req_data = '0;
    logic            rsp_valid;
    logic            rsp_stall = 1'b0;
    rsp_item_t       rsp_data;
    logic            cfg_valid = 1'b0;
    logic            cfg_ready;
    logic [TS_W-1:0] cfg_data = '0;

    // decoder copy kept by the bench
    logic [TS_W-1:0]    bit_limit = THRESHOLD_RESET;
    logic [TS_W-1:0]    last_stamp = '0;
    int                 edges_seen = 0;
    logic [FRAME_W-1:0] frame_shift = '0;

    rsp_item_t frame_reads[$];
    int        errors = 0;
    int        items_used = 0;
    bit        no_gaps = 1'b0;
    int        rsp_wait = 0;
    int        rsp_hold = 0;

    single_wire_sensor_frame_decoder u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    initial
    begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // update the decoder copy with one accepted request
    task automatic track_request(input req_item_t r);
        logic [TS_W-1:0] delta;
        logic [7:0]      sum;
        rsp_item_t       want;
        case (r.req_type)
            REQ_START:
            begin
                edges_seen = 0;
                frame_shift = '0;
                items_used++;
            end
            REQ_EDGE:
            begin
                if (edges_seen < MAX_EDGES)
                begin
                    edges_seen++;
                    if (edges_seen >= FIRST_BIT_EDGE && edges_seen <= LAST_BIT_EDGE)
                    begin
                        delta = r.timestamp - last_stamp;
                        frame_shift = {frame_shift[FRAME_W-2:0], delta >= bit_limit};
                    end
                    last_stamp = r.timestamp;
                    items_used++;
                end
            end
            REQ_READ:
            begin
                want = '0;
                if (edges_seen < LAST_BIT_EDGE)
                    want.frame_error = ERR_SHORT;
                else
                begin
                    want.humidity_whole       = frame_shift[HUM_WHOLE_LSB +: BYTE_W];
                    want.humidity_fraction    = frame_shift[HUM_FRAC_LSB +: BYTE_W];
                    want.temperature_whole    = frame_shift[TEMP_WHOLE_LSB +: BYTE_W];
                    want.temperature_fraction = frame_shift[TEMP_FRAC_LSB +: BYTE_W];
                    want.received_checksum    = frame_shift[CHECKSUM_LSB +: BYTE_W];
                    sum = want.humidity_whole + want.humidity_fraction
                        + want.temperature_whole + want.temperature_fraction;
                    want.frame_error = (sum != want.received_checksum) ? ERR_CHECKSUM
                                                                       : ERR_NONE;
                end
                frame_reads.push_back(want);
                items_used++;
            end
            default: ;
        endcase
    endtask

    // send one request after a random gap
    task automatic send_req(input logic [1:0] kind, input logic [TS_W-1:0] stamp);
        int        gap;
        req_item_t item;
        item.req_type  = kind;
        item.timestamp = stamp;
        gap = no_gaps ? 0 : $urandom_range(15, 0);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= item;
        do @(posedge clk); while (req_stall);
        track_request(item);
    endtask

    // wait until every result is back and the decode register is empty
    task automatic wait_quiet();
        req_valid <= 1'b0;
        while (frame_reads.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [TS_W-1:0] value);
        wait_quiet();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        bit_limit = value;
    endtask

    // edge spacing that decodes to the wanted bit, often right at the threshold
    function automatic logic [TS_W-1:0] bit_delta(input logic one);
        if (one)
            return ($urandom_range(3, 0) == 0) ? bit_limit
                                               : TS_W'($urandom_range(16'hFFFF, bit_limit));
        if (bit_limit == 0)
            return TS_W'($urandom);
        return ($urandom_range(3, 0) == 0) ? bit_limit - 1'b1
                                           : TS_W'($urandom_range(bit_limit - 1'b1, 0));
    endfunction

    function automatic logic [FRAME_W-1:0] make_frame(input bit good_sum);
        logic [31:0] body;
        logic [7:0]  sum;
        body = $urandom;
        case ($urandom_range(7, 0))
            0: body = '0;
            1: body = '1;
            default: ;
        endcase
        sum = body[31:24] + body[23:16] + body[15:8] + body[7:0];
        if (!good_sum)
            sum = sum ^ 8'($urandom_range(255, 1));
        return {body, sum};
    endfunction

    function automatic int pick_length();
        case ($urandom_range(9, 0))
            0: return $urandom_range(41, 0);
            1: return $urandom_range(63, 43);
            default: return LAST_BIT_EDGE;
        endcase
    endfunction

    // start, edges carrying the frame bits, then one read
    task automatic send_frame(input logic [FRAME_W-1:0] bits, input int edge_total);
        logic [TS_W-1:0] stamp;
        stamp = TS_W'($urandom);
        send_req(REQ_START, TS_W'($urandom));
        for (int e = 1; e <= edge_total; e++)
        begin
            if (e >= FIRST_BIT_EDGE && e <= LAST_BIT_EDGE)
                stamp = stamp + bit_delta(bits[LAST_BIT_EDGE - e]);
            else if (e > 1)
                stamp = stamp + TS_W'($urandom);
            send_req(REQ_EDGE, stamp);
        end
        send_req(REQ_READ, TS_W'($urandom));
    endtask

    // reads and edges outside any frame, unused request code
    task automatic test_idle_requests();
        send_req(REQ_READ, '0);
        send_req(REQ_UNUSED, 16'hFFFF);
        send_req(REQ_START, '0);
        send_req(REQ_EDGE, 16'hFFFF);
        send_req(REQ_EDGE, '0);
        send_req(REQ_READ, 16'hFFFF);
        send_req(REQ_UNUSED, '0);
        send_req(REQ_EDGE, 16'h8000);
        send_req(REQ_READ, 16'h5555);
        send_req(REQ_START, 16'hFFFF);
        send_req(REQ_READ, 16'hAAAA);
    endtask

    // too few edges, exact frame, trailing edges, saturation, repeated reads
    task automatic test_frame_lengths();
        int lengths[] = '{1, 2, 41, 43, 48, 63};
        send_frame('1, LAST_BIT_EDGE);
        send_frame('0, LAST_BIT_EDGE);
        send_req(REQ_READ, TS_W'($urandom));
        foreach (lengths[i])
            send_frame(make_frame(1'b1), lengths[i]);
        send_frame(make_frame(1'b0), LAST_BIT_EDGE);
        send_req(REQ_READ, TS_W'($urandom));
    endtask

    // threshold extremes and a few values in between
    task automatic test_thresholds();
        logic [TS_W-1:0] limits[] = '{16'h0000, 16'hFFFF, 16'h0001, 16'hFFFE,
                                      16'h0000, THRESHOLD_RESET};
        limits[4] = TS_W'($urandom);
        foreach (limits[i])
        begin
            write_threshold(limits[i]);
            send_frame(make_frame($urandom_range(3, 0) != 0), pick_length());
        end
    endtask

    // long receiver hold while reads keep coming, so the input backs up
    task automatic test_back_pressure();
        wait_quiet();
        no_gaps = 1'b1;
        rsp_hold = 400;
        repeat (30) send_req(REQ_READ, TS_W'($urandom));
        send_frame(make_frame(1'b1), LAST_BIT_EDGE);
        repeat (10) send_req(REQ_READ, TS_W'($urandom));
        no_gaps = 1'b0;
    endtask

    // mostly well-formed frames with random content, some noise in between
    task automatic test_random_traffic();
        int start_items;
        start_items = items_used;
        while (items_used - start_items < 200)
        begin
            no_gaps = ($urandom_range(7, 0) == 0);
            if ($urandom_range(15, 0) == 0)
                write_threshold(($urandom_range(1, 0) == 0) ? TS_W'($urandom)
                                                            : TS_W'($urandom_range(300, 0)));
            if ($urandom_range(9, 0) < 8)
                send_frame(make_frame($urandom_range(3, 0) != 0), pick_length());
            else
                repeat ($urandom_range(6, 1))
                    send_req(2'($urandom_range(3, 0)), TS_W'($urandom));
        end
        no_gaps = 1'b0;
    endtask

    // receiver: per-result wait drawn at random, plus a long hold on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
            rsp_wait = 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
                rsp_wait = no_gaps ? 0 : $urandom_range(15, 0);
            else if (rsp_valid && rsp_wait > 0)
                rsp_wait--;
            if (rsp_hold > 0)
                rsp_hold--;
            rsp_stall <= (rsp_wait > 0) || (rsp_hold > 0);
        end
    end

    function automatic void check_field(input string what, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
        end
    endfunction

    // compare each taken result with the oldest pending read
    always @(posedge clk)
    begin : rsp_check
        rsp_item_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (frame_reads.size() == 0)
            begin
                errors++;
                $display("%0t: result with no read pending, actual %h", $time, rsp_data);
            end
            else
            begin
                want = frame_reads.pop_front();
                check_field("humidity_whole", want.humidity_whole, rsp_data.humidity_whole);
                check_field("humidity_fraction", want.humidity_fraction,
                            rsp_data.humidity_fraction);
                check_field("temperature_whole", want.temperature_whole,
                            rsp_data.temperature_whole);
                check_field("temperature_fraction", want.temperature_fraction,
                            rsp_data.temperature_fraction);
                check_field("received_checksum", want.received_checksum,
                            rsp_data.received_checksum);
                check_field("frame_error", 8'(want.frame_error), 8'(rsp_data.frame_error));
            end
        end
    end

    // test sequence
    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_idle_requests();
        test_frame_lengths();
        test_thresholds();
        test_back_pressure();
        test_random_traffic();
        wait_quiet();
        repeat (8) @(posedge clk);
        if (errors == 0 && frame_reads.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
